>>> rtl/core/wdht_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Window drag hit test package
// Shared request and result types, codes and constants.
// ----------------------------------------------------------------------------
package wdht_pkg;

	localparam logic [1:0] CMD_POINTER = 2'd0;
	localparam logic [1:0] CMD_CREATE  = 2'd1;
	localparam logic [1:0] CMD_DESTROY = 2'd2;

	localparam logic [1:0] ST_DONE     = 2'd0;
	localparam logic [1:0] ST_FULL     = 2'd1;
	localparam logic [1:0] ST_NOTFOUND = 2'd2;
	localparam logic [1:0] ST_NOCHANGE = 2'd3;

	localparam logic [2:0] DK_NONE   = 3'd0;
	localparam logic [2:0] DK_MOVE   = 3'd1;
	localparam logic [2:0] DK_WIDTH  = 3'd2;
	localparam logic [2:0] DK_HEIGHT = 3'd3;
	localparam logic [2:0] DK_BOTH   = 3'd4;

	localparam logic [31:0] HANDLE_BASE_RESET = 32'd40000;
	localparam int CLOSE_OFF  = 28;
	localparam int CLOSE_SIZE = 24;
	localparam int CLOSE_TOP  = 4;

	localparam logic [2:0] REG_ENABLE = 3'd0;
	localparam logic [2:0] REG_TITLE  = 3'd1;
	localparam logic [2:0] REG_EDGE   = 3'd2;
	localparam logic [2:0] REG_MINW   = 3'd3;
	localparam logic [2:0] REG_MINH   = 3'd4;

	typedef struct packed {
		logic [1:0]         command;
		logic signed [15:0] x_pos;
		logic signed [15:0] y_pos;
		logic [14:0]        width_in;
		logic [14:0]        height_in;
		logic               button_down;
		logic [31:0]        handle_in;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [31:0]        handle_out;
		logic signed [15:0] rect_x;
		logic signed [15:0] rect_y;
		logic [14:0]        rect_w;
		logic [14:0]        rect_h;
		logic               drag_active_out;
		logic [2:0]         drag_mode_out;
	} res_t;

	typedef struct packed {
		logic       enable;
		logic [7:0] title_h;
		logic [5:0] edge_zone;
		logic [11:0] min_w;
		logic [11:0] min_h;
	} cfg_t;

	typedef struct packed {
		logic [15:0] left;
		logic [15:0] top;
		logic [14:0] width;
		logic [14:0] height;
		logic [31:0] handle;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

>>> rtl/core/window_drag_hit_test_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Window drag hit test unit
// Window table with create, destroy and pointer drag handling.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; a two-entry queue
// lets the host post a second request while the first is worked on.
// Each request yields one result, shown for one cycle with done high; the
// receiver cannot stall and takes it at once.
// Create is answered straight from the idle state. Destroy and a drag
// motion search the whole table top down, reading and then comparing each
// entry; a destroy that finds its window then compacts the table, reading
// and then copying each moved entry. A press hit-test walks from the
// topmost window, reading and then testing each entry; the single read
// port of the table RAM sets this read-then-check pace.
// Reset clears the window count and the drag state and returns the
// registers to their reset values; the table contents need no clearing.
// Registers are written over the APB port only while the unit is idle;
// the host must keep to this, as the unit itself does not enforce it.
// ----------------------------------------------------------------------------
module window_drag_hit_test_unit #(
	parameter int MAX_WINS = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  wdht_pkg::req_t req,
	output logic           busy,
	output logic           done,
	output wdht_pkg::res_t res,
	input  logic           psel,
	input  logic           penable,
	input  logic           pwrite,
	input  logic [4:0]     paddr,
	input  logic [31:0]    pwdata,
	output logic [31:0]    prdata,
	output logic           pready
);
	import wdht_pkg::*;

	cfg_t       cfg_q;
	logic       wr;
	logic       cancel;
	logic       q_valid, q_pop;
	req_t       q_req;
	logic [2:0] ridx;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;
	assign ridx   = paddr[4:2];
	assign cancel = wr && paddr[1:0] == 2'd0 && ridx == REG_ENABLE && !pwdata[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{enable: 1'b0, title_h: 8'd32, edge_zone: 6'd4,
				min_w: 12'd96, min_h: 12'd64};
		end else if (wr && paddr[1:0] == 2'd0) begin
			unique case (ridx)
				REG_ENABLE: cfg_q.enable    <= pwdata[0];
				REG_TITLE:  cfg_q.title_h   <= pwdata[7:0];
				REG_EDGE:   cfg_q.edge_zone <= pwdata[5:0];
				REG_MINW:   cfg_q.min_w     <= pwdata[11:0];
				REG_MINH:   cfg_q.min_h     <= pwdata[11:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (ridx)
			REG_ENABLE: prdata = {31'b0, cfg_q.enable};
			REG_TITLE:  prdata = {24'b0, cfg_q.title_h};
			REG_EDGE:   prdata = {26'b0, cfg_q.edge_zone};
			REG_MINW:   prdata = {20'b0, cfg_q.min_w};
			REG_MINH:   prdata = {20'b0, cfg_q.min_h};
			default:    prdata = '0;
		endcase
	end

	wdht_front u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .req(req), .busy(busy),
		.q_valid(q_valid), .q_req(q_req), .q_pop(q_pop)
	);

	wdht_back #(.MAX_WINS(MAX_WINS)) u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q), .cancel(cancel),
		.q_valid(q_valid && !q_pop), .q_req(q_req), .q_pop(q_pop),
		.done(done), .res(res)
	);
endmodule

>>> rtl/core/wdht_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Window drag hit test RAM
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module wdht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

>>> rtl/core/wdht_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Window drag hit test front end
// Accepts requests, holds them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module wdht_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  wdht_pkg::req_t req,
	output logic           busy,
	output logic           q_valid,
	output wdht_pkg::req_t q_req,
	input  logic           q_pop
);
	import wdht_pkg::*;

	req_t       slot_q [2];
	logic [1:0] cnt_q;
	logic       rd_q;
	logic       wr_q;
	logic       push;

	assign busy    = cnt_q[1];
	assign push    = start && !busy;
	assign q_valid = cnt_q != 2'd0;
	assign q_req   = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			rd_q  <= 1'b0;
			wr_q  <= 1'b0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (q_pop) begin
				rd_q <= !rd_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end
endmodule

>>> rtl/core/wdht_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Window drag hit test back end
// Walks the window table entry by entry, reading each entry before it is
// used, to search, hit-test and compact.
// ----------------------------------------------------------------------------
module wdht_back #(
	parameter int MAX_WINS = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  wdht_pkg::cfg_t cfg,
	input  logic           cancel,
	input  logic           q_valid,
	input  wdht_pkg::req_t q_req,
	output logic           q_pop,
	output logic           done,
	output wdht_pkg::res_t res
);
	import wdht_pkg::*;

	localparam int AW = (MAX_WINS > 1) ? $clog2(MAX_WINS) : 1;
	localparam int CW = $clog2(MAX_WINS + 1);

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_SRD   = 7'b0000010,
		S_SCAN  = 7'b0000100,
		S_HRD   = 7'b0001000,
		S_HIT   = 7'b0010000,
		S_CRD   = 7'b0100000,
		S_COPY  = 7'b1000000
	} state_t;

	state_t      state_q;
	req_t        r_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] idx_q;
	logic [31:0] base_q;
	logic        drag_q;
	logic [31:0] tgt_q;
	logic [2:0]  kind_q;
	logic signed [15:0] gpx_q, gpy_q, grx_q, gry_q;
	logic [14:0] grw_q, grh_q;
	logic [CW-1:0] slot_q;

	logic          we;
	logic [AW-1:0] waddr, raddr;
	entry_t        wdata, rdata;

	wdht_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_WINS)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	logic signed [17:0] ex, ey, wx, wy, ww, wh, ez, tb;
	logic in_rect, re, be, in_close;
	logic [2:0] hkind;
	always_comb begin
		ex = 18'(r_q.x_pos);
		ey = 18'(r_q.y_pos);
		wx = 18'(signed'(rdata.left));
		wy = 18'(signed'(rdata.top));
		ww = 18'({3'b0, rdata.width});
		wh = 18'({3'b0, rdata.height});
		ez = 18'({12'b0, cfg.edge_zone});
		tb = 18'({10'b0, cfg.title_h});
		in_rect = ex >= wx && ex < wx + ww && ey >= wy && ey < wy + wh;
		re = ex >= wx + ww - ez;
		be = ey >= wy + wh - ez;
		in_close = ex >= wx + ww - 18'(CLOSE_OFF) &&
			ex < wx + ww - 18'(CLOSE_OFF) + 18'(CLOSE_SIZE) &&
			ey >= wy + 18'(CLOSE_TOP) && ey < wy + 18'(CLOSE_TOP + CLOSE_SIZE);
		if (re && be) hkind = DK_BOTH;
		else if (re) hkind = DK_WIDTH;
		else if (be) hkind = DK_HEIGHT;
		else if (ey < wy + tb && !in_close) hkind = DK_MOVE;
		else hkind = DK_NONE;
	end

	// Drag motion arithmetic from the grab snapshot.
	logic signed [17:0] dx, dy, mx, my, nw, nh;
	logic [15:0] sx, sy;
	logic [14:0] cw, ch;
	always_comb begin
		dx = 18'(r_q.x_pos) - 18'(gpx_q);
		dy = 18'(r_q.y_pos) - 18'(gpy_q);
		mx = 18'(grx_q) + dx;
		my = 18'(gry_q) + dy;
		nw = 18'({3'b0, grw_q}) + dx;
		nh = 18'({3'b0, grh_q}) + dy;
		sx = (mx < -18'sd32768) ? 16'h8000 : (mx > 18'sd32767) ? 16'h7fff : mx[15:0];
		sy = (my < -18'sd32768) ? 16'h8000 : (my > 18'sd32767) ? 16'h7fff : my[15:0];
		cw = (nw < $signed(18'({6'b0, cfg.min_w}))) ? {3'b0, cfg.min_w} :
			(nw > 18'sd32767) ? 15'h7fff : nw[14:0];
		ch = (nh < $signed(18'({6'b0, cfg.min_h}))) ? {3'b0, cfg.min_h} :
			(nh > 18'sd32767) ? 15'h7fff : nh[14:0];
	end

	logic [CW-1:0] idx_n;
	assign idx_n = idx_q + CW'(1);

	always_comb begin
		we    = 1'b0;
		waddr = AW'(count_q);
		wdata = '0;
		raddr = AW'(idx_q);
		unique case (state_q)
			S_IDLE: begin
				we = q_valid && q_req.command == CMD_CREATE && count_q < CW'(MAX_WINS);
				wdata = '{left: q_req.x_pos, top: q_req.y_pos, width: q_req.width_in,
					height: q_req.height_in, handle: base_q + 32'd4};
			end
			S_SCAN: begin
				if (r_q.command == CMD_POINTER && rdata.handle == tgt_q) begin
					we    = 1'b1;
					waddr = AW'(idx_q);
					wdata = rdata;
					wdata.left = (kind_q == DK_MOVE) ? sx : grx_q;
					wdata.top  = (kind_q == DK_MOVE) ? sy : gry_q;
					if (kind_q != DK_MOVE) begin
						wdata.width  = (kind_q == DK_WIDTH || kind_q == DK_BOTH) ? cw : grw_q;
						wdata.height = (kind_q == DK_HEIGHT || kind_q == DK_BOTH) ? ch : grh_q;
					end
				end
			end
			S_CRD: raddr = AW'(idx_n);
			S_COPY: begin
				we    = 1'b1;
				waddr = AW'(idx_q);
				wdata = rdata;
				raddr = AW'(idx_n + CW'(1));
			end
			default: ;
		endcase
	end

	// The scan visits the entries from the top down and keeps the last matching
	// index, so the lowest match wins.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && q_valid) begin
			r_q <= q_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			idx_q   <= '0;
			slot_q  <= '0;
			base_q  <= HANDLE_BASE_RESET;
			drag_q  <= 1'b0;
			tgt_q   <= '0;
			kind_q  <= DK_NONE;
			gpx_q <= '0; gpy_q <= '0; grx_q <= '0; gry_q <= '0;
			grw_q <= '0; grh_q <= '0;
			q_pop <= 1'b0;
			done  <= 1'b0;
			res   <= '0;
		end else begin
			q_pop <= 1'b0;
			done  <= 1'b0;
			if (cancel) begin
				drag_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						q_pop <= 1'b1;
						res <= '{status: ST_NOCHANGE, handle_out: '0, rect_x: '0,
							rect_y: '0, rect_w: '0, rect_h: '0,
							drag_active_out: drag_q, drag_mode_out: drag_q ? kind_q : DK_NONE};
						if (q_req.command == CMD_CREATE) begin
							done <= 1'b1;
							if (count_q < CW'(MAX_WINS)) begin
								count_q <= count_q + CW'(1);
								base_q  <= base_q + 32'd5;
								res.status     <= ST_DONE;
								res.handle_out <= base_q + 32'd4;
								res.rect_x <= q_req.x_pos;
								res.rect_y <= q_req.y_pos;
								res.rect_w <= q_req.width_in;
								res.rect_h <= q_req.height_in;
							end else begin
								res.status <= ST_FULL;
							end
						end else if (q_req.command == CMD_DESTROY) begin
							idx_q <= count_q - CW'(1);
							slot_q <= count_q;
							if (count_q == '0) begin
								done <= 1'b1;
								res.status <= ST_NOTFOUND;
								res.handle_out <= q_req.handle_in;
							end else begin
								state_q <= S_SRD;
							end
						end else if (q_req.command == CMD_POINTER && cfg.enable) begin
							if (!q_req.button_down) begin
								drag_q <= 1'b0;
								done <= 1'b1;
								res.drag_active_out <= 1'b0;
								res.drag_mode_out <= DK_NONE;
							end else if (drag_q) begin
								idx_q <= count_q - CW'(1);
								slot_q <= count_q;
								if (count_q == '0) begin
									drag_q <= 1'b0;
									done <= 1'b1;
									res.status <= ST_NOTFOUND;
									res.handle_out <= tgt_q;
									res.drag_active_out <= 1'b0;
									res.drag_mode_out <= DK_NONE;
								end else begin
									state_q <= S_SRD;
								end
							end else if (count_q == '0) begin
								done <= 1'b1;
							end else begin
								idx_q <= count_q - CW'(1);
								state_q <= S_HRD;
							end
						end else begin
							done <= 1'b1;
						end
					end
				end
				S_SRD: state_q <= S_SCAN;
				S_SCAN: begin
					if (rdata.handle == ((r_q.command == CMD_DESTROY) ? r_q.handle_in : tgt_q)) begin
						slot_q <= idx_q;
						res.handle_out <= rdata.handle;
						if (r_q.command == CMD_DESTROY) begin
							res.rect_x <= rdata.left;
							res.rect_y <= rdata.top;
							res.rect_w <= rdata.width;
							res.rect_h <= rdata.height;
						end else begin
							res.rect_x <= wdata.left;
							res.rect_y <= wdata.top;
							res.rect_w <= wdata.width;
							res.rect_h <= wdata.height;
						end
					end
					if (idx_q == '0) begin
						state_q <= S_CRD;
						if (r_q.command == CMD_POINTER) begin
							state_q <= S_IDLE;
							done <= 1'b1;
							if (rdata.handle != tgt_q && slot_q == count_q) begin
								drag_q <= 1'b0;
								res.status <= ST_NOTFOUND;
								res.handle_out <= tgt_q;
								res.drag_active_out <= 1'b0;
								res.drag_mode_out <= DK_NONE;
							end else begin
								res.status <= ST_DONE;
							end
						end else if (rdata.handle != r_q.handle_in && slot_q == count_q) begin
							state_q <= S_IDLE;
							done <= 1'b1;
							res.status <= ST_NOTFOUND;
							res.handle_out <= r_q.handle_in;
						end else begin
							res.status <= ST_DONE;
							if (rdata.handle == r_q.handle_in) idx_q <= '0;
							else idx_q <= slot_q;
						end
					end else begin
						idx_q <= idx_q - CW'(1);
						state_q <= S_SRD;
					end
				end
				S_CRD: begin
					if (idx_n >= count_q) begin
						count_q <= count_q - CW'(1);
						done <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_COPY;
					end
				end
				S_COPY: begin
					idx_q <= idx_n;
					state_q <= S_CRD;
				end
				S_HRD: state_q <= S_HIT;
				S_HIT: begin
					if (in_rect) begin
						state_q <= S_IDLE;
						done <= 1'b1;
						if (hkind != DK_NONE) begin
							drag_q <= 1'b1;
							tgt_q <= rdata.handle;
							kind_q <= hkind;
							gpx_q <= r_q.x_pos; gpy_q <= r_q.y_pos;
							grx_q <= rdata.left; gry_q <= rdata.top;
							grw_q <= rdata.width; grh_q <= rdata.height;
							res.handle_out <= rdata.handle;
							res.rect_x <= rdata.left;
							res.rect_y <= rdata.top;
							res.rect_w <= rdata.width;
							res.rect_h <= rdata.height;
							res.drag_active_out <= 1'b1;
							res.drag_mode_out <= hkind;
						end
					end else if (idx_q == '0) begin
						state_q <= S_IDLE;
						done <= 1'b1;
					end else begin
						idx_q <= idx_q - CW'(1);
						state_q <= S_HRD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
